/* sv/affine_texture_span_shader_assert.svh */
// Assertion macros shared by the span shader RTL.
// Depends on clk and arst_n being visible in the module that expands them.
`ifndef AFFINE_TEXTURE_SPAN_SHADER_ASSERT_SVH
`define AFFINE_TEXTURE_SPAN_SHADER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ATSS_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define ATSS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/atss_pkg.sv */
// Shared types, codes and constants of the affine texture span shader.
// No dependencies; every module file imports it.
package atss_pkg;

	localparam int TEX_AXIS_BITS = 8;
	localparam int TEX_ADDR_W    = 2 * TEX_AXIS_BITS;
	localparam int TEX_DEPTH     = 1 << TEX_ADDR_W;
	localparam int UV_W          = 32;
	localparam int HALF_W        = UV_W / 2;
	localparam int TEXEL_W       = 16;
	localparam int BUMP_W        = 8;
	localparam int COLOR_W       = 8;
	localparam int LEFT_W        = 9;
	localparam int BG_W          = 8;
	localparam int LIGHT_W       = 16;
	localparam int NORM_W        = 5;
	localparam int DOT_W         = LIGHT_W + NORM_W + 2;
	localparam int CMD_W         = 2;
	localparam int IN_DATA_W     = 120;
	localparam int CFG_INDEX_W   = 3;
	localparam int CFG_DATA_W    = 16;

	// input item kinds
	localparam logic [CMD_W-1:0] CMD_TEX_WR  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_BUMP_WR = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SPAN    = 2'd2;
	localparam logic [CMD_W-1:0] CMD_PIXEL   = 2'd3;

	// shading modes
	localparam logic [1:0] MODE_TEXEL  = 2'd0;
	localparam logic [1:0] MODE_SHIFT  = 2'd1;
	localparam logic [1:0] MODE_NORMAL = 2'd2;
	localparam logic [1:0] MODE_BUMP   = 2'd3;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_SHADE_MODE = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HALF_RATE  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_LIGHT_X    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_LIGHT_Y    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_LIGHT_Z    = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_PAL_OFFSET = 3'd5;

	typedef struct packed {
		logic [1:0]                shade_mode;
		logic                      half_rate;
		logic signed [LIGHT_W-1:0] light_x;
		logic signed [LIGHT_W-1:0] light_y;
		logic signed [LIGHT_W-1:0] light_z;
		logic [COLOR_W-1:0]        pal_offset;
	} cfg_t;

	// pipeline moves: load stage 1, load stage 2, load the output register
	typedef struct packed {
		logic en1;
		logic en2;
		logic en_out;
	} pipe_ctl_t;

endpackage

/* sv/atss_regs.sv */
// Configuration register file of the span shader.
// Depends on atss_pkg.
module atss_regs
	import atss_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [CFG_INDEX_W-1:0] wr_index,
	input  logic [CFG_DATA_W-1:0]  wr_data,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_SHADE_MODE: cfg_q.shade_mode <= wr_data[1:0];
				REG_HALF_RATE:  cfg_q.half_rate  <= wr_data[0];
				REG_LIGHT_X:    cfg_q.light_x    <= wr_data;
				REG_LIGHT_Y:    cfg_q.light_y    <= wr_data;
				REG_LIGHT_Z:    cfg_q.light_z    <= wr_data;
				REG_PAL_OFFSET: cfg_q.pal_offset <= wr_data[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* sv/atss_coord.sv */
// Packed u/v coordinate accumulator with left-edge pre-advance.
// Depends on atss_pkg.
module atss_coord
	import atss_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     span_load,
	input  logic                     pixel_step,
	input  logic                     half_rate,
	input  logic [UV_W-1:0]          uv_start,
	input  logic [UV_W-1:0]          uv_step,
	input  logic signed [LEFT_W-1:0] span_left,
	output logic [TEX_ADDR_W-1:0]    texel_addr
);

	logic [UV_W-1:0]   uv_acc_q;
	logic [UV_W-1:0]   uv_step_q;
	logic [HALF_W-1:0] left_ext;
	logic [HALF_W-1:0] prod_hi;
	logic [HALF_W-1:0] prod_lo;
	logic [UV_W-1:0]   pre_adv;
	logic [UV_W-1:0]   uv_load;
	logic [UV_W-1:0]   step_eff;

	// each half of the step takes its own product, low 16 bits kept
	always_comb begin
		left_ext = {{(HALF_W-LEFT_W){span_left[LEFT_W-1]}}, span_left};
		prod_hi  = uv_step[UV_W-1:HALF_W] * left_ext;
		prod_lo  = uv_step[HALF_W-1:0] * left_ext;
		pre_adv  = {prod_hi, prod_lo};
		uv_load  = span_left[LEFT_W-1] ? (uv_start - pre_adv) : uv_start;
		step_eff = half_rate ? {uv_step_q[UV_W-2:0], 1'b0} : uv_step_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uv_acc_q  <= '0;
			uv_step_q <= '0;
		end else if (span_load) begin
			uv_acc_q  <= uv_load;
			uv_step_q <= uv_step;
		end else if (pixel_step) begin
			uv_acc_q  <= uv_acc_q + step_eff;
		end
	end

	assign texel_addr = {uv_acc_q[HALF_W-1 -: TEX_AXIS_BITS],
		uv_acc_q[UV_W-1 -: TEX_AXIS_BITS]};

endmodule

/* sv/atss_fetch.sv */
// Main texel store and pipeline stage 1 (texel read, background byte).
// Depends on atss_pkg.
module atss_fetch
	import atss_pkg::*;
(
	input  logic                  clk,
	input  pipe_ctl_t             ctl,
	input  logic                  wr_en,
	input  logic [TEX_ADDR_W-1:0] wr_addr,
	input  logic [TEXEL_W-1:0]    wr_data,
	input  logic [TEX_ADDR_W-1:0] rd_addr,
	input  logic [BG_W-1:0]       bg_byte,
	output logic [TEXEL_W-1:0]    texel_s1,
	output logic [BG_W-1:0]       bg_s1
);

	logic [TEXEL_W-1:0] main_texels [TEX_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			main_texels[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en1) begin
			texel_s1 <= main_texels[rd_addr];
			bg_s1    <= bg_byte;
		end
	end

endmodule

/* sv/atss_shade.sv */
// Shading stage 2, second (bump) table and the result register.
// Depends on atss_pkg.
module atss_shade
	import atss_pkg::*;
(
	input  logic                  clk,
	input  pipe_ctl_t             ctl,
	input  cfg_t                  cfg,
	input  logic                  wr_en,
	input  logic [TEX_ADDR_W-1:0] wr_addr,
	input  logic [BUMP_W-1:0]     wr_data,
	input  logic [TEXEL_W-1:0]    texel_s1,
	input  logic [BG_W-1:0]       bg_s1,
	output logic [COLOR_W-1:0]    pixel_color
);

	logic [BUMP_W-1:0]        bump_table [TEX_DEPTH];
	logic signed [NORM_W-1:0] nx;
	logic signed [NORM_W-1:0] ny;
	logic signed [NORM_W-1:0] nz;
	logic signed [DOT_W-1:0]  dot;
	logic [TEXEL_W-1:0]       ang_sum;
	logic [TEX_ADDR_W-1:0]    bump_addr;
	logic [COLOR_W-1:0]       color;
	logic [COLOR_W-1:0]       color_s2;
	logic [BUMP_W-1:0]        bump_s2;
	logic [COLOR_W-1:0]       pixel_color_q;

	always_comb begin
		nx        = texel_s1[15:11];
		ny        = texel_s1[10:6];
		nz        = texel_s1[5:1];
		dot       = DOT_W'($signed(cfg.light_x)) * DOT_W'(nx)
			+ DOT_W'($signed(cfg.light_y)) * DOT_W'(ny)
			+ DOT_W'($signed(cfg.light_z)) * DOT_W'(nz);
		ang_sum   = texel_s1 + cfg.light_x;
		bump_addr = {ang_sum[TEXEL_W-2 -: TEX_AXIS_BITS], texel_s1[TEX_AXIS_BITS-1:0]};
		case (cfg.shade_mode)
			MODE_TEXEL:  color = texel_s1[COLOR_W-1:0];
			// shift of 8 or more clears the byte
			MODE_SHIFT:  color = (texel_s1[7:3] != '0) ? '0 : (bg_s1 >> texel_s1[2:0]);
			MODE_NORMAL: color = dot[15:8] + cfg.pal_offset;
			default:     color = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			bump_table[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en2) begin
			color_s2 <= color;
			bump_s2  <= bump_table[bump_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_out) begin
			pixel_color_q <= (cfg.shade_mode == MODE_BUMP) ? bump_s2 : color_s2;
		end
	end

	assign pixel_color = pixel_color_q;

endmodule

/* sv/affine_texture_span_shader.sv */
// Affine texture span shader. Takes one item per clock unless all stages are full
// and the output stalls: texel and bump-table writes, span starts and pixels, chosen
// by s_tuser. Each pixel item gives one palette index on m_tdata after the texel read,
// the shade and bump-table read and the result register; other items give nothing.
// The sustained rate is one item per cycle while the output does not stall, set by the
// single 32-bit coordinate add that feeds back between pixels. The input side keeps
// taking beats while a result waits, until all three stages are full. Both 64K-entry
// stores have no reset; reading an entry never written returns whatever the RAM holds.
// Depends on atss_pkg and the atss_* submodules.
module affine_texture_span_shader
	import atss_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// tex_addr[15:0], tex_data[31:16], uv_start[63:32], uv_step[95:64],
	// span_left[104:96], bg_byte[112:105], zero fill above
	input  logic [IN_DATA_W-1:0]   s_tdata,
	// cmd[1:0]
	input  logic [CMD_W-1:0]       s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// pixel_color[7:0]
	output logic [COLOR_W-1:0]     m_tdata,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	`include "affine_texture_span_shader_assert.svh"

	cfg_t                     cfg;
	pipe_ctl_t                ctl;
	logic                     in_beat;
	logic                     is_tex_wr;
	logic                     is_bump_wr;
	logic                     is_span;
	logic                     is_pixel;
	logic                     v1_q;
	logic                     v2_q;
	logic                     vout_q;
	logic [TEX_ADDR_W-1:0]    tex_addr;
	logic [TEXEL_W-1:0]       tex_data;
	logic [UV_W-1:0]          uv_start;
	logic [UV_W-1:0]          uv_step;
	logic signed [LEFT_W-1:0] span_left;
	logic [BG_W-1:0]          bg_byte;
	logic [TEX_ADDR_W-1:0]    rd_addr;
	logic [TEXEL_W-1:0]       texel_s1;
	logic [BG_W-1:0]          bg_s1;

	assign tex_addr  = s_tdata[15:0];
	assign tex_data  = s_tdata[31:16];
	assign uv_start  = s_tdata[63:32];
	assign uv_step   = s_tdata[95:64];
	assign span_left = s_tdata[104:96];
	assign bg_byte   = s_tdata[112:105];

	// bubbles collapse: a stage moves when the next one is empty or moving
	always_comb begin
		ctl.en_out = !vout_q || m_tready;
		ctl.en2    = !v2_q || ctl.en_out;
		ctl.en1    = !v1_q || ctl.en2;
	end

	assign s_tready   = ctl.en1;
	assign cfg_ready  = 1'b1;
	assign in_beat    = s_tvalid && s_tready;
	assign is_tex_wr  = in_beat && (s_tuser == CMD_TEX_WR);
	assign is_bump_wr = in_beat && (s_tuser == CMD_BUMP_WR);
	assign is_span    = in_beat && (s_tuser == CMD_SPAN);
	assign is_pixel   = in_beat && (s_tuser == CMD_PIXEL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q   <= 1'b0;
			v2_q   <= 1'b0;
			vout_q <= 1'b0;
		end else begin
			if (ctl.en1) begin
				v1_q <= is_pixel;
			end
			if (ctl.en2) begin
				v2_q <= v1_q;
			end
			if (ctl.en_out) begin
				vout_q <= v2_q;
			end
		end
	end

	assign m_tvalid = vout_q;

	atss_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	atss_coord u_coord (
		.clk        (clk),
		.arst_n     (arst_n),
		.span_load  (is_span),
		.pixel_step (is_pixel),
		.half_rate  (cfg.half_rate),
		.uv_start   (uv_start),
		.uv_step    (uv_step),
		.span_left  (span_left),
		.texel_addr (rd_addr)
	);

	atss_fetch u_fetch (
		.clk      (clk),
		.ctl      (ctl),
		.wr_en    (is_tex_wr),
		.wr_addr  (tex_addr),
		.wr_data  (tex_data),
		.rd_addr  (rd_addr),
		.bg_byte  (bg_byte),
		.texel_s1 (texel_s1),
		.bg_s1    (bg_s1)
	);

	atss_shade u_shade (
		.clk         (clk),
		.ctl         (ctl),
		.cfg         (cfg),
		.wr_en       (is_bump_wr),
		.wr_addr     (tex_addr),
		.wr_data     (tex_data[BUMP_W-1:0]),
		.texel_s1    (texel_s1),
		.bg_s1       (bg_s1),
		.pixel_color (m_tdata)
	);

	`ATSS_ASSERT_NOW(a_ready_only_full, !s_tready, v1_q && v2_q && vout_q, "input stalled with a free stage")
	`ATSS_ASSERT_NEXT(a_pixel_enters, is_pixel, v1_q, "accepted pixel did not reach stage 1")
	`ATSS_ASSERT_NEXT(a_nonpixel_empty, in_beat && !is_pixel, !v1_q, "non-pixel beat filled stage 1")
	`ATSS_ASSERT_NEXT(a_s2_holds, v2_q && vout_q && !m_tready, v2_q && vout_q, "stage 2 lost under stall")

endmodule

/* test/affine_texture_span_shader_checker.sv */
`timescale 1ns / 1ps
// Checker for the affine texture span shader: watches the input, result and register
// channels, predicts each pixel's palette index and compares it with every result beat.
// Depends on atss_pkg.
module affine_texture_span_shader_checker
	import atss_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_DATA_W-1:0]   s_tdata,
	input  logic [CMD_W-1:0]       s_tuser,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [COLOR_W-1:0]     m_tdata,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     mismatches,
	output int                     outstanding
);

	typedef struct packed {
		logic [6:0]               fill;
		logic [BG_W-1:0]          bg_byte;
		logic signed [LEFT_W-1:0] span_left;
		logic [UV_W-1:0]          uv_step;
		logic [UV_W-1:0]          uv_start;
		logic [TEXEL_W-1:0]       tex_data;
		logic [TEX_ADDR_W-1:0]    tex_addr;
	} beat_t;

	cfg_t               regs;
	logic [UV_W-1:0]    coord;
	logic [UV_W-1:0]    coord_step;
	logic [TEXEL_W-1:0] texels [TEX_DEPTH];
	logic [BUMP_W-1:0]  bump_rows [TEX_DEPTH];
	logic [COLOR_W-1:0] colors_due [$];
	logic [COLOR_W-1:0] due;
	logic [UV_W-1:0]    reach;
	beat_t              beat;
	int                 errs;

	function automatic logic [COLOR_W-1:0] shade(input logic [TEXEL_W-1:0] texel,
			input logic [BG_W-1:0] bg);
		logic signed [31:0] lx, ly, lz, nx, ny, nz, dot;
		logic [31:0]        turned;
		lx = {{16{regs.light_x[15]}}, regs.light_x};
		ly = {{16{regs.light_y[15]}}, regs.light_y};
		lz = {{16{regs.light_z[15]}}, regs.light_z};
		// three signed 5-bit normal components
		nx = {{27{texel[15]}}, texel[15:11]};
		ny = {{27{texel[10]}}, texel[10:6]};
		nz = {{27{texel[5]}}, texel[5:1]};
		dot = lx * nx + ly * ny + lz * nz;
		turned = {16'h0000, texel} + lx;
		case (regs.shade_mode)
			MODE_TEXEL:  return texel[7:0];
			MODE_SHIFT:  return (texel[7:0] > 8'd7) ? '0 : bg >> texel[2:0];
			MODE_NORMAL: return dot[15:8] + regs.pal_offset;
			default:     return bump_rows[{turned[14:7], texel[7:0]}];
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs <= '0;
			coord <= '0;
			coord_step <= '0;
			colors_due.delete();
			errs = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (colors_due.size() == 0) begin
					$error("pixel_color: no beat expected, actual %0d", m_tdata);
					errs++;
				end else begin
					due = colors_due.pop_front();
					if (m_tdata !== due) begin
						$error("pixel_color: expected %0d, actual %0d", due, m_tdata);
						errs++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SHADE_MODE: regs.shade_mode <= cfg_data[1:0];
					REG_HALF_RATE:  regs.half_rate <= cfg_data[0];
					REG_LIGHT_X:    regs.light_x <= cfg_data;
					REG_LIGHT_Y:    regs.light_y <= cfg_data;
					REG_LIGHT_Z:    regs.light_z <= cfg_data;
					REG_PAL_OFFSET: regs.pal_offset <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				beat = s_tdata;
				case (s_tuser)
					CMD_TEX_WR:  texels[beat.tex_addr] <= beat.tex_data;
					CMD_BUMP_WR: bump_rows[beat.tex_addr] <= beat.tex_data[7:0];
					CMD_SPAN: begin
						// advance past the clipped pixels, each half on its own
						reach = {{23{beat.span_left[8]}}, beat.span_left};
						coord <= beat.span_left[8] ? beat.uv_start
							- (((beat.uv_step & 32'hFFFF_0000) * reach)
							| ((beat.uv_step * reach) & 32'h0000_FFFF)) : beat.uv_start;
						coord_step <= beat.uv_step;
					end
					default: begin
						colors_due.push_back(shade(texels[{coord[15:8], coord[31:24]}],
							beat.bg_byte));
						coord <= coord + (regs.half_rate ? coord_step << 1 : coord_step);
					end
				endcase
			end
			mismatches <= errs;
			outstanding <= colors_due.size();
		end
	end

endmodule

/* test/affine_texture_span_shader_tb.sv */
`timescale 1ns / 1ps
// Top of the span shader testbench: clock, reset, register writes and input beats.
// Depends on atss_pkg, affine_texture_span_shader and affine_texture_span_shader_checker.
module affine_texture_span_shader_tb;
	import atss_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS  = 1650;
	localparam int PHASES        = 12;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata = '0;
	logic [CMD_W-1:0]       s_tuser = CMD_TEX_WR;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [COLOR_W-1:0]     m_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_SHADE_MODE;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	int                     mismatches;
	int                     outstanding;
	int                     send_idle_pct = 0;
	int                     recv_idle_pct = 0;
	int                     items_sent = 0;
	int                     cycle_count = 0;

	// sender-side view, kept so that no pixel reads a store entry never written
	logic [1:0]         mode_now = MODE_TEXEL;
	logic               half_now = 1'b0;
	logic [15:0]        light_x_now = '0;
	logic [UV_W-1:0]    coord = '0;
	logic [UV_W-1:0]    coord_step = '0;
	logic [TEXEL_W-1:0] tex_val [TEX_DEPTH];
	bit                 tex_known [TEX_DEPTH];
	bit                 bump_known [TEX_DEPTH];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("affine_texture_span_shader test failed");
			$finish;
		end
	end

	affine_texture_span_shader dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	affine_texture_span_shader_checker span_check (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	function automatic logic [15:0] light_pick();
		case ($urandom_range(3))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// half of the texels get a low byte of 0 to 9, which for 0 to 7 shifts the background by less than 8
	function automatic logic [TEXEL_W-1:0] any_texel();
		return $urandom_range(1) ? 16'($urandom) : {8'($urandom), 8'($urandom_range(0, 9))};
	endfunction

	task automatic send(input logic [CMD_W-1:0] cmd, input logic [15:0] addr,
			input logic [15:0] data, input logic [31:0] start, input logic [31:0] step,
			input logic [8:0] left, input logic [7:0] bg);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {7'd0, bg, left, step, start, data, addr};
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	task automatic put_texel(input logic [15:0] addr, input logic [15:0] data);
		send(CMD_TEX_WR, addr, data, $urandom, $urandom, 9'($urandom), 8'($urandom));
		tex_val[addr] = data;
		tex_known[addr] = 1'b1;
	endtask

	task automatic put_bump(input logic [15:0] addr, input logic [15:0] data);
		send(CMD_BUMP_WR, addr, data, $urandom, $urandom, 9'($urandom), 8'($urandom));
		bump_known[addr] = 1'b1;
	endtask

	task automatic span(input logic [31:0] start, input logic [31:0] step,
			input logic [8:0] left);
		logic [31:0] reach;
		reach = {{23{left[8]}}, left};
		send(CMD_SPAN, 16'($urandom), 16'($urandom), start, step, left, 8'($urandom));
		coord = left[8] ? start - (((step & 32'hFFFF_0000) * reach)
			| ((step * reach) & 32'h0000_FFFF)) : start;
		coord_step = step;
	endtask

	// fill in whatever the pixel is about to read, then send it
	task automatic pixel(input logic [7:0] bg);
		logic [15:0] slot;
		logic [31:0] turned;
		slot = {coord[15:8], coord[31:24]};
		if (!tex_known[slot])
			put_texel(slot, any_texel());
		if (mode_now == MODE_BUMP) begin
			turned = {16'h0000, tex_val[slot]} + {{16{light_x_now[15]}}, light_x_now};
			slot = {turned[14:7], tex_val[slot][7:0]};
			if (!bump_known[slot])
				put_bump(slot, 16'($urandom));
		end
		send(CMD_PIXEL, 16'($urandom), 16'($urandom), $urandom, $urandom, 9'($urandom), bg);
		coord = coord + (half_now ? coord_step << 1 : coord_step);
	endtask

	// hold input until every result is out and the pipe has flushed
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic configure(input logic [1:0] mode, input logic half, input logic [15:0] lx,
			input logic [15:0] ly, input logic [15:0] lz, input logic [7:0] pal);
		settle();
		write_reg(REG_SHADE_MODE, {14'($urandom), mode});
		write_reg(REG_HALF_RATE, {15'($urandom), half});
		write_reg(REG_LIGHT_X, lx);
		write_reg(REG_LIGHT_Y, ly);
		write_reg(REG_LIGHT_Z, lz);
		write_reg(REG_SPARE, 16'($urandom));
		write_reg(REG_PAL_OFFSET, {8'($urandom), pal});
		cfg_valid <= 1'b0;
		mode_now = mode;
		half_now = half;
		light_x_now = lx;
	endtask

	initial begin
		int phase_end;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 15;
		recv_idle_pct = 47;
		configure(MODE_TEXEL, 1'b0, 16'h0000, 16'h0000, 16'h0000, 8'h00);
		put_texel(16'h0000, 16'hFFFF);
		put_texel(16'hFFFF, 16'h00A5);
		span(32'h0000_0000, 32'h0000_0000, 9'h000);
		pixel(8'hFF);
		span(32'hFFFF_FFFF, 32'h0000_0000, 9'h0FF);
		pixel(8'h00);
		// most negative edge with the largest step, then a one-pixel clip
		span(32'hFFFF_FFFF, 32'h7FFF_FFFF, 9'h100);
		pixel(8'hFF);
		pixel(8'h00);
		span(32'h0000_0000, 32'h8000_0000, 9'h1FF);
		pixel(8'h5A);

		configure(MODE_SHIFT, 1'b1, 16'h7FFF, 16'h8000, 16'h0001, 8'hFF);
		span(32'h3400_1200, 32'h0000_0000, 9'h000);
		put_texel(16'h1234, 16'hFF07);
		pixel(8'hFF);
		put_texel(16'h1234, 16'h0008);
		pixel(8'hFF);
		put_texel(16'h1234, 16'h00FF);
		pixel(8'hFF);

		configure(MODE_NORMAL, 1'b0, 16'h7FFF, 16'h8000, 16'h7FFF, 8'hFF);
		put_texel(16'h1234, 16'h8420);
		pixel(8'h00);
		put_texel(16'h1234, 16'h7BDE);
		pixel(8'h00);

		configure(MODE_BUMP, 1'b1, 16'h8000, 16'h0000, 16'h0000, 8'h00);
		put_texel(16'h1234, 16'hFFFF);
		pixel(8'h00);

		for (int p = 0; p < PHASES; p++) begin
			case (p / 4)
				0: begin
					send_idle_pct = 15;
					recv_idle_pct = 47;
				end
				1: begin
					send_idle_pct = 47;
					recv_idle_pct = 15;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			configure(2'(p), 1'($urandom), light_pick(), light_pick(), light_pick(),
				($urandom_range(3) == 0) ? 8'hFF : 8'($urandom));
			phase_end = items_sent + RANDOM_ITEMS / PHASES;
			while (items_sent < phase_end) begin
				case ($urandom_range(9))
					0: put_texel(16'($urandom), any_texel());
					1: put_bump(16'($urandom), 16'($urandom));
					2: pixel(8'($urandom));
					default: begin
						// start near the origin a third of the time to revisit texels
						span($urandom_range(2) == 0
								? {6'd0, 10'($urandom), 6'd0, 10'($urandom)} : $urandom,
							$urandom_range(1) ? $urandom
								: {16'($urandom_range(0, 1023)) - 16'd512,
								   16'($urandom_range(0, 1023)) - 16'd512},
							9'($urandom));
						repeat ($urandom_range(0, 16)) pixel(8'($urandom));
					end
				endcase
			end
		end

		settle();
		if (mismatches == 0) begin
			$display("affine_texture_span_shader test passed");
		end else begin
			$display("affine_texture_span_shader test failed");
		end
		$finish;
	end

endmodule
